@@ sv/odsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odsv_pkg
// Shared types and constants of the oscillator divider solver.
// ----------------------------------------------------------------------------
package odsv_pkg;

    localparam int RATE_W  = 31;
    localparam int XTAL_W  = 44;
    localparam int PROD_W  = 43;
    localparam int RFREQ_W = 38;
    localparam int FRAC_W  = 28;
    localparam int HS_W    = 4;
    localparam int HIDX_W  = 3;
    localparam int DIV_STEPS = PROD_W + XTAL_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS);

    localparam logic [RATE_W-1:0] FREQ_MIN = RATE_W'(10000000);
    localparam logic [RATE_W-1:0] BAND1_LO = RATE_W'(945000000);
    localparam logic [RATE_W-1:0] BAND1_HI = RATE_W'(970000000);
    localparam logic [RATE_W-1:0] BAND2_LO = RATE_W'(1134000000);
    localparam logic [RATE_W-1:0] BAND2_HI = RATE_W'(1212500000);
    localparam logic [PROD_W-1:0] DCO_MIN  = PROD_W'(64'd4850000000);
    localparam logic [PROD_W-1:0] DCO_MAX  = PROD_W'(64'd5670000000);
    localparam logic [XTAL_W-1:0] XTAL_RESET = XTAL_W'(64'd7489781760000);

    localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(5);
    localparam logic [HS_W-1:0]   HS_DIRECT_HI = HS_W'(4);
    localparam logic [HS_W-1:0]   HS_DIRECT_LO = HS_W'(5);

    localparam logic [1:0] STATUS_EXACT   = 2'd0;
    localparam logic [1:0] STATUS_CLAMPED = 2'd1;
    localparam logic [1:0] STATUS_NO_PAIR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_DECIDE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } odsv_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic load_out;
    } odsv_cmd_t;

    typedef struct packed {
        logic direct;
        logic last_cand;
        logic found;
        logic out_free;
    } odsv_sts_t;

    function automatic logic [HS_W-1:0] hs_value(input logic [HIDX_W-1:0] idx);
        logic [HS_W-1:0] v;
        case (idx)
            3'd0: v = 4'd4;
            3'd1: v = 4'd5;
            3'd2: v = 4'd6;
            3'd3: v = 4'd7;
            3'd4: v = 4'd9;
            3'd5: v = 4'd11;
            default: v = 4'd4;
        endcase
        return v;
    endfunction

endpackage

@@ sv/odsv_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odsv_ctrl
// Sequencer: accept, divider search, RFREQ division and result hand-off.
// ----------------------------------------------------------------------------
module odsv_ctrl
    import odsv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  odsv_sts_t sts,
    output odsv_cmd_t cmd,
    output logic      div_start,
    input  logic      div_done
);

    odsv_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        div_start  = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.direct ? ST_DIV_START : ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.step = 1'b1;
                if (sts.last_cand) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = sts.found ? ST_DIV_START : ST_FINISH;
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/odsv_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odsv_div
// Restoring bit-serial divider: floor(dividend * 2^44 / divisor), one bit
// per cycle, low 38 quotient bits kept.
// ----------------------------------------------------------------------------
module odsv_div
    import odsv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [PROD_W-1:0]  dividend,
    input  logic [XTAL_W-1:0]  divisor,
    output logic               done,
    output logic [RFREQ_W-1:0] quotient
);

    logic               busy_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0]  shift_reg;
    logic [XTAL_W-1:0]  dvs_reg;
    logic [XTAL_W-1:0]  rem_reg;
    logic [RFREQ_W-1:0] quo_reg;
    logic [XTAL_W:0]    trial;
    logic               take;

    assign trial    = {rem_reg, shift_reg[PROD_W-1]};
    assign take     = (trial >= {1'b0, dvs_reg});
    assign done     = busy_reg && (cnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            dvs_reg   <= divisor;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[PROD_W-2:0], 1'b0};
            rem_reg   <= take ? XTAL_W'(trial - {1'b0, dvs_reg}) : trial[XTAL_W-1:0];
            quo_reg   <= {quo_reg[RFREQ_W-2:0], take};
        end
    end

endmodule

@@ sv/odsv_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odsv_dp
// Datapath: clamping, candidate evaluation, crystal register and the
// packed result register.
// ----------------------------------------------------------------------------
module odsv_dp
    import odsv_pkg::*;
#(
    parameter int N1_LIMIT = 128
)(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [XTAL_W-1:0]  cfg_xtal_freq,
    input  logic [RATE_W-1:0]  s_target_freq,
    input  odsv_cmd_t          cmd,
    output odsv_sts_t          sts,
    output logic [PROD_W-1:0]  prod,
    output logic [XTAL_W-1:0]  xtal,
    input  logic [RFREQ_W-1:0] rfreq,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_reg_byte_7,
    output logic [7:0]         m_reg_byte_8,
    output logic [7:0]         m_reg_byte_9,
    output logic [7:0]         m_reg_byte_10,
    output logic [7:0]         m_reg_byte_11,
    output logic [7:0]         m_reg_byte_12,
    output logic [RATE_W-1:0]  m_adjusted_freq,
    output logic [1:0]         m_status
);

    localparam int N1_W = $clog2(N1_LIMIT + 1);

    logic [XTAL_W-1:0] xtal_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              clamped_reg;
    logic              direct_reg;
    logic              found_reg;
    logic [HS_W-1:0]   hs_reg;
    logic [N1_W-1:0]   n1_reg;
    logic [PROD_W-1:0] best_reg;
    logic [PROD_W-1:0] rate_n1_reg;
    logic [N1_W-1:0]   m_reg;
    logic [HIDX_W-1:0] h_reg;
    logic              m_valid_reg;
    logic [7:0]        b7_reg, b8_reg, b9_reg, b10_reg, b11_reg, b12_reg;
    logic [RATE_W-1:0] adj_reg;
    logic [1:0]        status_reg;

    logic [RATE_W-1:0] rate_c;
    logic              clamp_c;
    logic              direct_c;
    logic [HS_W-1:0]   hs_direct;
    logic [PROD_W-1:0] prod_direct;
    logic [HS_W-1:0]   hs_cand;
    logic [PROD_W-1:0] p_cand;
    logic              keep;
    logic [N1_W:0]     m_next;
    logic [7:0]        n1_full;
    logic [6:0]        n1c;
    logic [2:0]        hsc;
    logic [9:0]        rhi;
    logic [FRAC_W-1:0] rlo;

    always_comb begin
        rate_c  = s_target_freq;
        clamp_c = 1'b0;
        if (rate_c < FREQ_MIN) begin
            rate_c  = FREQ_MIN;
            clamp_c = 1'b1;
        end
        if (rate_c > BAND1_LO && rate_c < BAND1_HI) begin
            rate_c  = BAND1_LO;
            clamp_c = 1'b1;
        end
        if (rate_c > BAND2_LO && rate_c < BAND2_HI) begin
            rate_c  = BAND2_LO;
            clamp_c = 1'b1;
        end
    end

    assign direct_c    = (rate_c >= BAND1_HI);
    assign hs_direct   = (rate_c >= BAND2_HI) ? HS_DIRECT_HI : HS_DIRECT_LO;
    assign prod_direct = {PROD_W'(rate_c) << 2}
                       + ((rate_c >= BAND2_HI) ? '0 : PROD_W'(rate_c));

    assign hs_cand = hs_value(h_reg);
    assign p_cand  = rate_n1_reg * PROD_W'(hs_cand);
    assign keep    = (p_cand >= DCO_MIN) && (p_cand <= best_reg);
    assign m_next  = (m_reg == N1_W'(1)) ? (N1_W+1)'(2) : ((N1_W+1)'(m_reg) + (N1_W+1)'(2));

    assign sts.direct    = direct_reg;
    assign sts.last_cand = (h_reg == HIDX_LAST) && (m_next > (N1_W+1)'(N1_LIMIT));
    assign sts.found     = found_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign prod = best_reg;
    assign xtal = xtal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xtal_reg <= XTAL_RESET;
        end else if (cfg_valid) begin
            xtal_reg <= cfg_xtal_freq;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rate_reg    <= rate_c;
            clamped_reg <= clamp_c;
            direct_reg  <= direct_c;
            found_reg   <= direct_c;
            hs_reg      <= hs_direct;
            n1_reg      <= N1_W'(1);
            best_reg    <= direct_c ? prod_direct : DCO_MAX;
            rate_n1_reg <= PROD_W'(rate_c);
            m_reg       <= N1_W'(1);
            h_reg       <= '0;
        end else if (cmd.step) begin
            if (keep) begin
                best_reg  <= p_cand;
                hs_reg    <= hs_cand;
                n1_reg    <= m_reg;
                found_reg <= 1'b1;
            end
            if (h_reg == HIDX_LAST) begin
                h_reg       <= '0;
                m_reg       <= m_next[N1_W-1:0];
                rate_n1_reg <= PROD_W'(rate_reg) * PROD_W'(m_next);
            end else begin
                h_reg <= h_reg + 1'b1;
            end
        end
    end

    // result packing
    assign n1_full = 8'(n1_reg) - 8'd1;
    assign n1c     = n1_full[6:0];
    assign hsc     = 3'(hs_reg - HS_DIRECT_HI);
    assign rhi     = rfreq[RFREQ_W-1:FRAC_W];
    assign rlo     = rfreq[FRAC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            adj_reg <= rate_reg;
            if (found_reg) begin
                b7_reg     <= {hsc, n1c[6:2]};
                b8_reg     <= {n1c[1:0], rhi[9:4]};
                b9_reg     <= {rhi[3:0], rlo[27:24]};
                b10_reg    <= rlo[23:16];
                b11_reg    <= rlo[15:8];
                b12_reg    <= rlo[7:0];
                status_reg <= clamped_reg ? STATUS_CLAMPED : STATUS_EXACT;
            end else begin
                b7_reg     <= '0;
                b8_reg     <= '0;
                b9_reg     <= '0;
                b10_reg    <= '0;
                b11_reg    <= '0;
                b12_reg    <= '0;
                status_reg <= STATUS_NO_PAIR;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_reg_byte_7    = b7_reg;
    assign m_reg_byte_8    = b8_reg;
    assign m_reg_byte_9    = b9_reg;
    assign m_reg_byte_10   = b10_reg;
    assign m_reg_byte_11   = b11_reg;
    assign m_reg_byte_12   = b12_reg;
    assign m_adjusted_freq = adj_reg;
    assign m_status        = status_reg;

endmodule

@@ sv/oscillator_divider_solver_core.sv @@
`timescale 1ns / 1ps
// Throughput: one item at a time; the next input is taken in the cycle after the result is loaded;
//   one HS/N1 candidate per cycle in the search, one quotient bit per cycle over 87 steps.
// The next item is taken while a finished result waits in the output register.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, crystal 114.285 MHz.
// ----------------------------------------------------------------------------
// oscillator_divider_solver_core
// HS/N1 divider search and RFREQ computation for a programmable oscillator.
// ----------------------------------------------------------------------------
module oscillator_divider_solver_core
    import odsv_pkg::*;
#(
    parameter int N1_LIMIT = 128
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [XTAL_W-1:0] cfg_xtal_freq,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [RATE_W-1:0] s_target_freq,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_reg_byte_7,
    output logic [7:0]        m_reg_byte_8,
    output logic [7:0]        m_reg_byte_9,
    output logic [7:0]        m_reg_byte_10,
    output logic [7:0]        m_reg_byte_11,
    output logic [7:0]        m_reg_byte_12,
    output logic [RATE_W-1:0] m_adjusted_freq,
    output logic [1:0]        m_status
);

    odsv_cmd_t          cmd;
    odsv_sts_t          sts;
    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  prod;
    logic [XTAL_W-1:0]  xtal;
    logic [RFREQ_W-1:0] rfreq;

    assign cfg_ready = 1'b1;

    odsv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd),
        .div_start (div_start),
        .div_done  (div_done)
    );

    odsv_dp #(
        .N1_LIMIT (N1_LIMIT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_xtal_freq   (cfg_xtal_freq),
        .s_target_freq   (s_target_freq),
        .cmd             (cmd),
        .sts             (sts),
        .prod            (prod),
        .xtal            (xtal),
        .rfreq           (rfreq),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reg_byte_7    (m_reg_byte_7),
        .m_reg_byte_8    (m_reg_byte_8),
        .m_reg_byte_9    (m_reg_byte_9),
        .m_reg_byte_10   (m_reg_byte_10),
        .m_reg_byte_11   (m_reg_byte_11),
        .m_reg_byte_12   (m_reg_byte_12),
        .m_adjusted_freq (m_adjusted_freq),
        .m_status        (m_status)
    );

    odsv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod),
        .divisor  (xtal),
        .done     (div_done),
        .quotient (rfreq)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the oscillator divider solver core. Target
// frequencies go in over a valid/ready channel and each solution (six
// register bytes, clamped frequency, status) is checked against an
// in-bench solver that repeats the clamp, the HS/N1 search and the RFREQ
// division. Crystal settings are changed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
    import odsv_pkg::*;

    localparam logic [63:0] HZ_FLOOR    = 64'd10000000;
    localparam logic [63:0] BAND_A_LO   = 64'd945000000;
    localparam logic [63:0] BAND_A_HI   = 64'd970000000;
    localparam logic [63:0] BAND_B_LO   = 64'd1134000000;
    localparam logic [63:0] BAND_B_HI   = 64'd1212500000;
    localparam logic [63:0] DCO_LOW_HZ  = 64'd4850000000;
    localparam logic [63:0] DCO_HIGH_HZ = 64'd5670000000;
    localparam logic [43:0] XTAL_DEFAULT = 44'd7489781760000;
    localparam int          N1_MAX      = 128;
    localparam int          SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [7:0]  rb7;
        logic [7:0]  rb8;
        logic [7:0]  rb9;
        logic [7:0]  rb10;
        logic [7:0]  rb11;
        logic [7:0]  rb12;
        logic [30:0] adjusted;
        logic [1:0]  status;
    } osc_regs_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [XTAL_W-1:0] cfg_xtal_freq;
    logic              s_valid;
    logic              s_ready;
    logic [RATE_W-1:0] s_target_freq;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_reg_byte_7;
    logic [7:0]        m_reg_byte_8;
    logic [7:0]        m_reg_byte_9;
    logic [7:0]        m_reg_byte_10;
    logic [7:0]        m_reg_byte_11;
    logic [7:0]        m_reg_byte_12;
    logic [RATE_W-1:0] m_adjusted_freq;
    logic [1:0]        m_status;

    osc_regs_t   predicted_settings [$];
    logic [43:0] xtal_model;
    osc_regs_t   got_regs;
    osc_regs_t   exp_regs;
    int          mismatches    = 0;
    int          targets_sent  = 0;
    int          results_seen  = 0;
    int          clamped_seen  = 0;
    int          direct_seen   = 0;
    int          xtal_writes   = 0;
    int          hold_request  = 0;
    int          hold_left     = 0;
    int          mode_left     = 0;
    rx_mode_t    rx_mode       = RX_ALWAYS;

    always #2 aclk = ~aclk;

    oscillator_divider_solver_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_xtal_freq   (cfg_xtal_freq),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_target_freq   (s_target_freq),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reg_byte_7    (m_reg_byte_7),
        .m_reg_byte_8    (m_reg_byte_8),
        .m_reg_byte_9    (m_reg_byte_9),
        .m_reg_byte_10   (m_reg_byte_10),
        .m_reg_byte_11   (m_reg_byte_11),
        .m_reg_byte_12   (m_reg_byte_12),
        .m_adjusted_freq (m_adjusted_freq),
        .m_status        (m_status)
    );

    function automatic osc_regs_t solve_dividers(input logic [30:0] target,
                                                 input logic [43:0] xtal);
        osc_regs_t   r;
        logic [63:0] rate;
        logic [63:0] best;
        logic [63:0] p;
        logic [63:0] prod;
        logic [86:0] quot;
        logic [37:0] rf;
        logic [6:0]  n1_code;
        logic [2:0]  hs_code;
        int          hs_ladder [6];
        int          hs;
        int          n1;
        hs_ladder = '{4, 5, 6, 7, 9, 11};
        r = '0;
        r.status = STATUS_EXACT;
        rate = 64'(target);
        if (rate < HZ_FLOOR) begin
            rate = HZ_FLOOR;
            r.status = STATUS_CLAMPED;
        end
        if (rate > BAND_A_LO && rate < BAND_A_HI) begin
            rate = BAND_A_LO;
            r.status = STATUS_CLAMPED;
        end
        if (rate > BAND_B_LO && rate < BAND_B_HI) begin
            rate = BAND_B_LO;
            r.status = STATUS_CLAMPED;
        end
        r.adjusted = rate[30:0];
        hs = 0;
        n1 = 0;
        if (rate >= BAND_B_HI) begin
            hs = 4;
            n1 = 1;
        end else if (rate >= BAND_A_HI) begin
            hs = 5;
            n1 = 1;
        end else begin
            best = DCO_HIGH_HZ;
            for (int m = 1; m <= N1_MAX; m++) begin
                if (m == 1 || m % 2 == 0) begin
                    for (int h = 0; h < 6; h++) begin
                        p = rate * 64'(hs_ladder[h]) * 64'(m);
                        if (p >= DCO_LOW_HZ && p <= best) begin
                            best = p;
                            hs = hs_ladder[h];
                            n1 = m;
                        end
                    end
                end
            end
        end
        if (hs == 0) begin
            r.status = STATUS_NO_PAIR;
        end else begin
            prod = rate * 64'(hs) * 64'(n1);
            // a zero crystal drives the serial divider to all ones
            if (xtal == '0) begin
                rf = '1;
            end else begin
                quot = {prod[42:0], 44'd0} / {43'd0, xtal};
                rf = quot[37:0];
            end
            hs_code = 3'(hs - 4);
            n1_code = 7'(n1 - 1);
            r.rb7  = {hs_code, n1_code[6:2]};
            r.rb8  = {n1_code[1:0], rf[37:32]};
            r.rb9  = rf[31:24];
            r.rb10 = rf[23:16];
            r.rb11 = rf[15:8];
            r.rb12 = rf[7:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] pick_target();
        logic [31:0] base;
        logic [30:0] t;
        case ($urandom_range(0, 9))
            0, 1: t = 31'($urandom);
            2, 3, 4, 5: t = 31'($urandom_range(10000000, 945000000));
            6: t = 31'($urandom_range(0, 9999999));
            7: begin
                if ($urandom_range(0, 1) == 0)
                    t = 31'($urandom_range(945000001, 969999999));
                else
                    t = 31'($urandom_range(1134000001, 1212499999));
            end
            8: begin
                case ($urandom_range(0, 4))
                    0: base = 32'd10000000;
                    1: base = 32'd945000000;
                    2: base = 32'd970000000;
                    3: base = 32'd1134000000;
                    default: base = 32'd1212500000;
                endcase
                t = 31'(base + $urandom_range(0, 6) - 3);
            end
            default: t = 31'($urandom_range(970000000, 2147483647));
        endcase
        return t;
    endfunction

    function automatic logic [43:0] pick_xtal();
        logic [43:0] x;
        case ($urandom_range(0, 3))
            0: x = XTAL_DEFAULT;
            1: x = 44'({$urandom, $urandom});
            2: x = 44'((64'($urandom_range(100000000, 160000000)) << 16)
                       | 64'($urandom_range(0, 65535)));
            default: x = 44'($urandom_range(1, 1 << 20));
        endcase
        return x;
    endfunction

    function automatic int pick_gap();
        int g;
        case ($urandom_range(0, 7))
            0: g = 0;
            6: g = $urandom_range(20, 200);
            7: g = $urandom_range(200, 600);
            default: g = $urandom_range(1, 20);
        endcase
        return g;
    endfunction

    task automatic send_freq(input logic [30:0] f);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_target_freq <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted_settings.push_back(solve_dividers(f, xtal_model));
        targets_sent++;
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predicted_settings.size() != 0) @(posedge aclk);
    endtask

    task automatic write_xtal(input logic [43:0] v);
        @(negedge aclk);
        cfg_valid     <= 1'b1;
        cfg_xtal_freq <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        xtal_model = v;
        xtal_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_clamp_edges();
        logic [30:0] clamp_points [16];
        clamp_points = '{31'd0, 31'd9999999, 31'd10000000, 31'd10000001,
                         31'd156250000, 31'd945000000, 31'd945000001,
                         31'd969999999, 31'd970000000, 31'd1133999999,
                         31'd1134000000, 31'd1134000001, 31'd1212499999,
                         31'd1212500000, 31'd1212500001, 31'h7FFFFFFF};
        foreach (clamp_points[i]) send_freq(clamp_points[i]);
        wait_drained();
    endtask

    task automatic test_xtal_extremes();
        logic [43:0] corners [3];
        corners = '{44'd1, '1, 44'd0};
        foreach (corners[i]) begin
            wait_drained();
            write_xtal(corners[i]);
            send_freq(31'd10000000);
            send_freq(31'h7FFFFFFF);
        end
        wait_drained();
        write_xtal(XTAL_DEFAULT);
    endtask

    // receiver held off while the sender keeps offering: the output register
    // and the solver both fill, and the input must stall
    task automatic test_output_backpressure();
        wait_drained();
        hold_request = 1500;
        repeat (4) send_freq(31'($urandom_range(10000000, 945000000)));
        wait_drained();
    endtask

    task automatic test_random_targets();
        int burst_left;
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            write_xtal((phase == 0) ? XTAL_DEFAULT : pick_xtal());
            burst_left = 0;
            repeat (95) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    idle_sender(pick_gap());
                end
                send_freq(pick_target());
                burst_left--;
            end
        end
        wait_drained();
    endtask

    task automatic report_mismatch(input string why, input osc_regs_t e,
                                   input osc_regs_t g);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("%0t %s: exp %h %h %h %h %h %h adj %0d st %0d",
                     $time, why, e.rb7, e.rb8, e.rb9, e.rb10, e.rb11, e.rb12,
                     e.adjusted, e.status);
            $display("%0t %s: got %h %h %h %h %h %h adj %0d st %0d",
                     $time, why, g.rb7, g.rb8, g.rb9, g.rb10, g.rb11, g.rb12,
                     g.adjusted, g.status);
        end
    endtask

    // result transfers, checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_regs = '{m_reg_byte_7, m_reg_byte_8, m_reg_byte_9, m_reg_byte_10,
                         m_reg_byte_11, m_reg_byte_12, m_adjusted_freq, m_status};
            if (predicted_settings.size() == 0) begin
                report_mismatch("unexpected result", '0, got_regs);
            end else begin
                exp_regs = predicted_settings.pop_front();
                results_seen++;
                if (exp_regs.status == STATUS_CLAMPED)
                    clamped_seen++;
                if (64'(exp_regs.adjusted) >= BAND_A_HI)
                    direct_seen++;
                if (got_regs.rb7 !== exp_regs.rb7 || got_regs.rb8 !== exp_regs.rb8
                    || got_regs.rb9 !== exp_regs.rb9 || got_regs.rb10 !== exp_regs.rb10
                    || got_regs.rb11 !== exp_regs.rb11 || got_regs.rb12 !== exp_regs.rb12
                    || got_regs.adjusted !== exp_regs.adjusted
                    || got_regs.status !== exp_regs.status)
                    report_mismatch("mismatch", exp_regs, got_regs);
            end
        end
    end

    // receiver stall pattern, with a counted hold-off on request
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(64, 512);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                default:   m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_xtal_freq = '0;
        s_valid       = 1'b0;
        s_target_freq = '0;
        m_ready       = 1'b0;
        xtal_model    = XTAL_DEFAULT;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_clamp_edges();
        test_xtal_extremes();
        test_output_backpressure();
        test_random_targets();

        wait_drained();
        repeat (600) @(posedge aclk);

        $display("Run covered %0d targets over %0d crystal writes: %0d clamped, %0d direct band",
                 targets_sent, xtal_writes, clamped_seen, direct_seen);
        $display("Results checked: %0d, mismatches: %0d", results_seen, mismatches);
        if (mismatches == 0 && predicted_settings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #15000000;
        $display("Timed out waiting for transfers");
        $display("TEST FAILED");
        $finish;
    end

endmodule
